>>> hw/rtl/rswm_pkg.sv
package rswm_pkg;

    // default sizing
    localparam int DEPTH_DEF    = 1024;
    localparam int INIT_CAP_DEF = 10;

    localparam int WORD_W = 32;
    localparam int STS_W  = 2;
    localparam int CAP_OW = 12;
    localparam int CNT_OW = 11;

    // request kinds
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // result status codes
    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic                     req_type;
        logic signed [WORD_W-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] pop_value;
        logic [STS_W-1:0]         status;
        logic [CAP_OW-1:0]        logical_capacity;
        logic [CNT_OW-1:0]        item_count;
        logic [CNT_OW-1:0]        peak_count;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic wr_push;    // accepted push, room left
        logic rd_pop;     // accepted pop, stack not empty
        logic rej_empty;  // accepted pop on empty stack
        logic rej_full;   // accepted push on full store
        logic pop_done;   // read data of the pop is back
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_sts;

endpackage

>>> hw/rtl/rswm_ram.sv
module rswm_ram #(
    parameter int W = 32,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/rswm_ctrl.sv
module rswm_ctrl import rswm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_req_type,
    input  t_sts i_sts,
    output logic o_busy,
    output t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;   // waiting on RAM read data

    logic r_state;
    logic n_state;
    logic accept;

    assign o_busy = (r_state == S_POP);
    assign accept = i_start & ~o_busy;

    always_comb begin
        o_cmd           = '0;
        o_cmd.wr_push   = accept & (i_req_type == REQ_PUSH) & ~i_sts.full;
        o_cmd.rej_full  = accept & (i_req_type == REQ_PUSH) &  i_sts.full;
        o_cmd.rd_pop    = accept & (i_req_type == REQ_POP)  & ~i_sts.empty;
        o_cmd.rej_empty = accept & (i_req_type == REQ_POP)  &  i_sts.empty;
        o_cmd.pop_done  = (r_state == S_POP);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.rd_pop) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/rswm_dp.sv
module rswm_dp import rswm_pkg::*; #(
    parameter int DEPTH            = DEPTH_DEF,
    parameter int INITIAL_CAPACITY = INIT_CAP_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic signed [WORD_W-1:0] i_push_value,
    output t_sts                     o_sts,
    output logic                     o_done,
    output t_rsp                     o_rsp
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_MAX = (INITIAL_CAPACITY > 2 * DEPTH) ? INITIAL_CAPACITY : 2 * DEPTH;
    localparam int CAP_W   = $clog2(CAP_MAX + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic [CAP_W-1:0] r_cap,   n_cap;
    logic [CNT_W-1:0] r_peak,  n_peak;
    logic             r_done,  n_done;
    t_rsp             r_rsp,   n_rsp;

    logic [CNT_W-1:0]  cnt_p1;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CAP_W-1:0]  cap_dbl;
    logic [CAP_W-1:0]  cap_half;
    logic [WORD_W-1:0] ram_rdata;

    assign cnt_p1   = r_count + CNT_W'(1);
    assign cnt_m1   = r_count - CNT_W'(1);
    assign cap_dbl  = r_cap << 1;
    assign cap_half = r_cap >> 1;

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == CNT_W'(DEPTH));

    rswm_ram #(
        .W (WORD_W),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_push),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_push_value),
        .i_re    (i_cmd.rd_pop),
        .i_raddr (cnt_m1[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_count = r_count;
        n_cap   = r_cap;
        n_peak  = r_peak;
        n_done  = 1'b0;
        n_rsp   = r_rsp;

        if (i_cmd.wr_push) begin
            // grow capacity when the push lands on a full logical array
            if (CAP_W'(r_count) == r_cap) begin
                n_cap = (cap_dbl == '0) ? CAP_W'(2) : cap_dbl;
            end
            n_count = cnt_p1;
            if (cnt_p1 > r_peak) begin
                n_peak = cnt_p1;
            end
        end
        if (i_cmd.rd_pop) begin
            // shrink before the pop when well under half full
            if (CAP_W'(r_count) + CAP_W'(1) < cap_half) begin
                n_cap = cap_half;
            end
            n_count = cnt_m1;
        end

        if (i_cmd.wr_push || i_cmd.rej_full || i_cmd.rej_empty || i_cmd.pop_done) begin
            n_done                 = 1'b1;
            n_rsp.pop_value        = '0;
            n_rsp.status           = STS_OK;
            n_rsp.logical_capacity = CAP_OW'(n_cap);
            n_rsp.item_count       = CNT_OW'(n_count);
            n_rsp.peak_count       = CNT_OW'(n_peak);
            if (i_cmd.rej_full) begin
                n_rsp.status = STS_FULL;
            end
            if (i_cmd.rej_empty) begin
                n_rsp.status = STS_EMPTY;
            end
            if (i_cmd.pop_done) begin
                n_rsp.pop_value = ram_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_W'(INITIAL_CAPACITY);
            r_peak  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_cap   <= n_cap;
            r_peak  <= n_peak;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

>>> hw/rtl/resizing_stack_with_watermark_unit.sv
// LIFO of signed 32-bit words with a logical capacity and a peak-count
// watermark. A request transfer happens on a rising edge with start high
// and busy low; every request yields exactly one result transfer, shown on
// o_rsp for one cycle with o_done high, and the receiver cannot stall it.
// Results: a push, a pop on an empty stack and a push on a full store give
// their result in the cycle after the request and keep busy low, so these
// can be issued every cycle. For a pop of a held word, the store RAM has a
// registered read port, so busy is high for the one cycle in which the
// read data returns, and the result follows in the next cycle.
// Capacity doubles on a push that finds the count equal to it (zero becomes
// two), halves on a non-empty pop when count + 1 < capacity / 2. A full
// store (count == DEPTH) drops pushes with a full status; a pop on an empty
// stack returns zero with an empty status. No clearing pass after reset:
// only entries written by earlier pushes are ever read.
module resizing_stack_with_watermark_unit import rswm_pkg::*; #(
    parameter int DEPTH            = DEPTH_DEF,
    parameter int INITIAL_CAPACITY = INIT_CAP_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    t_cmd cmd;
    t_sts sts;

    // Controller: request decode and the pop read-wait state.
    rswm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_sts      (sts),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    // Datapath: count, capacity, peak, store RAM and the result register.
    rswm_dp #(
        .DEPTH            (DEPTH),
        .INITIAL_CAPACITY (INITIAL_CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_push_value (i_req.push_value),
        .o_sts        (sts),
        .o_done       (o_done),
        .o_rsp        (o_rsp)
    );

    // The read wait of a pop never lasts more than one cycle.
    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // Every accepted request either answers next cycle or is in its pop read.
    a_req_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("accepted request produced no result");

    // A pop read always ends in a result.
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_done)
        else $error("pop read finished without a result");

    // Empty status comes only from an empty stack and carries zero data.
    a_empty_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == STS_EMPTY) |->
            (o_rsp.item_count == '0 && o_rsp.pop_value == '0))
        else $error("empty status with data or items");

endmodule
